// File: design/rhc_pkg.sv
// Shared types and constants for the RGB to HSL conversion pipeline.
// No dependencies; used by rhc_front, rhc_div_cell and the top level.
`default_nettype none

package rhc_pkg;

    localparam int CHAN_W    = 8;
    localparam int QUO_W     = 16;
    localparam int HUE_REM_W = 11;
    localparam int SAT_REM_W = 8;
    localparam int LIGHT_W   = 9;
    localparam int DIV_STEPS = QUO_W;

    typedef struct packed {
        logic [HUE_REM_W-1:0] hue_rem;
        logic [HUE_REM_W-1:0] hue_div;
        logic [QUO_W-1:0]     hue_bits;
        logic [SAT_REM_W-1:0] sat_rem;
        logic [SAT_REM_W-1:0] sat_div;
        logic [QUO_W-1:0]     sat_bits;
        logic [LIGHT_W-1:0]   lightness;
        logic                 achromatic;
    } word_t;

endpackage

`default_nettype wire

// File: design/rgb_to_hsl_convert_core.sv
// RGB to HSL converter: front stage feeding a row of 16 division cells.
// Registered stages from input acceptance to m_valid: 1 front + 16 cells.
// Throughput: one pixel per cycle while m_ready is high; each cell holds one word and passes it on.
// A stalled output backs up cell by cell; bubbles in the row still fill.
// Reset (aresetn low, synchronous) clears all valid bits; no data is reset.
// Depends on rhc_pkg, rhc_front and rhc_div_cell.
`default_nettype none

module rgb_to_hsl_convert_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [rhc_pkg::CHAN_W-1:0]   s_red,
    input  wire logic [rhc_pkg::CHAN_W-1:0]   s_green,
    input  wire logic [rhc_pkg::CHAN_W-1:0]   s_blue,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [rhc_pkg::QUO_W-1:0]         m_hue,
    output logic [rhc_pkg::QUO_W-1:0]         m_saturation,
    output logic [rhc_pkg::LIGHT_W-1:0]       m_lightness,
    output logic                              m_achromatic
);

    logic           valid_chain [rhc_pkg::DIV_STEPS+1];
    logic           ready_chain [rhc_pkg::DIV_STEPS+1];
    rhc_pkg::word_t word_chain  [rhc_pkg::DIV_STEPS+1];

    rhc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .valid_in  (s_valid),
        .ready_out (s_ready),
        .red       (s_red),
        .green     (s_green),
        .blue      (s_blue),
        .valid_out (valid_chain[0]),
        .ready_in  (ready_chain[0]),
        .word_out  (word_chain[0])
    );

    for (genvar i = 0; i < rhc_pkg::DIV_STEPS; i++) begin : g_cell
        rhc_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .valid_in  (valid_chain[i]),
            .ready_out (ready_chain[i]),
            .word_in   (word_chain[i]),
            .valid_out (valid_chain[i+1]),
            .ready_in  (ready_chain[i+1]),
            .word_out  (word_chain[i+1])
        );
    end

    assign ready_chain[rhc_pkg::DIV_STEPS] = m_ready;

    assign m_valid      = valid_chain[rhc_pkg::DIV_STEPS];
    assign m_hue        = word_chain[rhc_pkg::DIV_STEPS].hue_bits;
    assign m_saturation = word_chain[rhc_pkg::DIV_STEPS].sat_bits;
    assign m_lightness  = word_chain[rhc_pkg::DIV_STEPS].lightness;
    assign m_achromatic = word_chain[rhc_pkg::DIV_STEPS].achromatic;

endmodule

`default_nettype wire

// File: design/rhc_front.sv
// Front stage: max/min search, lightness, and setup of both long divisions.
// Depends on rhc_pkg for word_t and widths.
`default_nettype none

module rhc_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      valid_in,
    output logic                           ready_out,
    input  wire logic [rhc_pkg::CHAN_W-1:0] red,
    input  wire logic [rhc_pkg::CHAN_W-1:0] green,
    input  wire logic [rhc_pkg::CHAN_W-1:0] blue,
    output logic                           valid_out,
    input  wire logic                      ready_in,
    output rhc_pkg::word_t                 word_out
);

    logic                            valid_reg;
    rhc_pkg::word_t                  word_reg;
    rhc_pkg::word_t                  word_next;
    logic [rhc_pkg::CHAN_W-1:0]      mx;
    logic [rhc_pkg::CHAN_W-1:0]      mn;
    logic [rhc_pkg::CHAN_W-1:0]      d;
    logic [rhc_pkg::CHAN_W-1:0]      rd;
    logic [rhc_pkg::CHAN_W-1:0]      gd;
    logic [rhc_pkg::CHAN_W-1:0]      bd;
    logic [rhc_pkg::LIGHT_W-1:0]     sum;
    logic [rhc_pkg::SAT_REM_W-1:0]   den;
    logic [rhc_pkg::HUE_REM_W-1:0]   d1;
    logic [rhc_pkg::HUE_REM_W-1:0]   d3;
    logic [rhc_pkg::HUE_REM_W-1:0]   d5;
    logic [rhc_pkg::HUE_REM_W-1:0]   d6;
    logic [rhc_pkg::HUE_REM_W-1:0]   n;

    assign ready_out = !valid_reg || ready_in;
    assign valid_out = valid_reg;
    assign word_out  = word_reg;

    always_comb begin
        mx = (red > green) ? red : green;
        mx = (mx > blue) ? mx : blue;
        mn = (red < green) ? red : green;
        mn = (mn < blue) ? mn : blue;
        d  = mx - mn;
        rd = mx - red;
        gd = mx - green;
        bd = mx - blue;
        sum = {1'b0, mx} + {1'b0, mn};
        den = (sum <= rhc_pkg::LIGHT_W'(255)) ? sum[rhc_pkg::SAT_REM_W-1:0]
                                               : rhc_pkg::SAT_REM_W'(9'd510 - sum);
        d1 = rhc_pkg::HUE_REM_W'(d);
        d3 = (d1 << 1) + d1;
        d5 = (d1 << 2) + d1;
        d6 = (d1 << 2) + (d1 << 1);

        if (red == mx) begin
            if (green == mn) begin
                // pure red with equal green and blue wraps to zero
                n = (blue == mn) ? '0 : d5 + rhc_pkg::HUE_REM_W'(bd);
            end else begin
                n = d1 - rhc_pkg::HUE_REM_W'(gd);
            end
        end else if (green == mx) begin
            n = (blue == mn) ? d1 + rhc_pkg::HUE_REM_W'(rd)
                             : d3 - rhc_pkg::HUE_REM_W'(bd);
        end else begin
            n = (red == mn) ? d3 + rhc_pkg::HUE_REM_W'(gd)
                            : d5 - rhc_pkg::HUE_REM_W'(rd);
        end

        word_next.lightness = sum;
        if (d == '0) begin
            word_next.achromatic = 1'b1;
            word_next.hue_rem    = '0;
            word_next.hue_div    = rhc_pkg::HUE_REM_W'(1);
            word_next.hue_bits   = '0;
            word_next.sat_rem    = '0;
            word_next.sat_div    = rhc_pkg::SAT_REM_W'(1);
            word_next.sat_bits   = '0;
        end else begin
            word_next.achromatic = 1'b0;
            word_next.hue_rem    = n;
            word_next.hue_div    = d6;
            word_next.hue_bits   = '0;
            // d*65535 split as (d-1)*65536 + (65536-d)
            word_next.sat_rem    = d - rhc_pkg::CHAN_W'(1);
            word_next.sat_div    = den;
            word_next.sat_bits   = rhc_pkg::QUO_W'(17'h10000 - {9'b0, d});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_out) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (valid_in && ready_out) begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

// File: design/rhc_div_cell.sv
// One restoring-division cell: one quotient bit for hue and one for saturation.
// Depends on rhc_pkg for word_t and widths.
`default_nettype none

module rhc_div_cell (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     valid_in,
    output logic          ready_out,
    input  wire rhc_pkg::word_t word_in,
    output logic          valid_out,
    input  wire logic     ready_in,
    output rhc_pkg::word_t word_out
);

    logic                          valid_reg;
    rhc_pkg::word_t                word_reg;
    rhc_pkg::word_t                word_next;
    logic [rhc_pkg::HUE_REM_W:0]   hue_trial;
    logic [rhc_pkg::SAT_REM_W:0]   sat_trial;
    logic                          hue_ge;
    logic                          sat_ge;

    assign ready_out = !valid_reg || ready_in;
    assign valid_out = valid_reg;
    assign word_out  = word_reg;

    always_comb begin
        hue_trial = {word_in.hue_rem, word_in.hue_bits[rhc_pkg::QUO_W-1]};
        sat_trial = {word_in.sat_rem, word_in.sat_bits[rhc_pkg::QUO_W-1]};
        hue_ge    = hue_trial >= {1'b0, word_in.hue_div};
        sat_ge    = sat_trial >= {1'b0, word_in.sat_div};

        word_next          = word_in;
        word_next.hue_rem  = hue_ge ? rhc_pkg::HUE_REM_W'(hue_trial - {1'b0, word_in.hue_div})
                                    : rhc_pkg::HUE_REM_W'(hue_trial);
        word_next.sat_rem  = sat_ge ? rhc_pkg::SAT_REM_W'(sat_trial - {1'b0, word_in.sat_div})
                                    : rhc_pkg::SAT_REM_W'(sat_trial);
        word_next.hue_bits = {word_in.hue_bits[rhc_pkg::QUO_W-2:0], hue_ge};
        word_next.sat_bits = {word_in.sat_bits[rhc_pkg::QUO_W-2:0], sat_ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_out) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (valid_in && ready_out) begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

// File: design/rhc_checker.sv
// Port-level checks for rgb_to_hsl_convert_core, attached by bind.
// Depends on rhc_pkg for field widths.
`default_nettype none

module rhc_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [rhc_pkg::QUO_W-1:0]  m_hue,
    input wire logic [rhc_pkg::QUO_W-1:0]  m_saturation,
    input wire logic [rhc_pkg::LIGHT_W-1:0] m_lightness,
    input wire logic                       m_achromatic
);

    a_gray_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_achromatic |-> m_hue == '0 && m_saturation == '0)
        else $error("gray word with nonzero hue or saturation");

    a_light_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_lightness <= rhc_pkg::LIGHT_W'(510))
        else $error("lightness out of range");

    a_extreme_gray: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_lightness == '0 || m_lightness == rhc_pkg::LIGHT_W'(510))
        |-> m_achromatic)
        else $error("black or white word not flagged achromatic");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped before acceptance");

endmodule

bind rgb_to_hsl_convert_core rhc_checker u_rhc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hue        (m_hue),
    .m_saturation (m_saturation),
    .m_lightness  (m_lightness),
    .m_achromatic (m_achromatic)
);

`default_nettype wire
